FILE: sv/mrrc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the response checker.
`timescale 1ns / 1ps
`default_nettype none

package mrrc_pkg;

  // Burst limit and derived widths
  localparam int BURST_BYTES = 64;
  localparam int POS_W       = $clog2(BURST_BYTES + 1);
  localparam int LEN_W       = 9;
  localparam int START_W     = 6;
  localparam int FLEN_W      = 7;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // CRC constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register indexes on the APB port
  localparam logic [1:0] REG_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_LENGTH   = 2'd2;

  // Length rule codes
  localparam logic [1:0] RULE_BYTE_COUNT = 2'd0;
  localparam logic [1:0] RULE_FIXED3     = 2'd1;
  localparam logic [1:0] RULE_FIXED4     = 2'd2;
  localparam logic [1:0] RULE_FIXED6     = 2'd3;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] function_code;
    logic [1:0] length_rule;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_burst;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [START_W-1:0]  frame_start;
    logic [FLEN_W-1:0]   frame_length;
  } result_t;

  // One byte of the Modbus CRC-16, reflected, unrolled over eight bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mrrc_cfg.sv
// APB register file: expected address, expected function code, length rule.
`timescale 1ns / 1ps
`default_nettype none

module mrrc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mrrc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mrrc_pkg::PDATA_W-1:0] pwdata,
  output logic      [mrrc_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output mrrc_pkg::cfg_t                   cfg
);
  import mrrc_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address       <= 8'd1;
      cfg.function_code <= 8'd3;
      cfg.length_rule   <= RULE_BYTE_COUNT;
    end else if (wr_en) begin
      case (reg_index)
        REG_ADDRESS:  cfg.address       <= pwdata[7:0];
        REG_FUNCTION: cfg.function_code <= pwdata[7:0];
        REG_LENGTH:   cfg.length_rule   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_index)
      REG_ADDRESS:  prdata = {24'd0, cfg.address};
      REG_FUNCTION: prdata = {24'd0, cfg.function_code};
      REG_LENGTH:   prdata = {30'd0, cfg.length_rule};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/mrrc_in_reg.sv
// Input register: holds one received word until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module mrrc_in_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                end_of_burst,
  input  wire logic                take,
  output logic                     held_valid,
  output mrrc_pkg::in_word_t       held
);
  import mrrc_pkg::*;

  assign in_ready = !held_valid || take;

  // Control: fill on accept, drain when the parser takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload: load on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held.rx_byte      <= rx_byte;
      held.end_of_burst <= end_of_burst;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mrrc_parser.sv
// Frame parser: address/function hunt, body length, CRC check, burst end.
`timescale 1ns / 1ps
`default_nettype none

module mrrc_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire mrrc_pkg::in_word_t  word,
  input  wire mrrc_pkg::cfg_t      cfg,
  output logic                     res_valid,
  output mrrc_pkg::result_t        res
);
  import mrrc_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_BODY,
    PH_CRCLO,
    PH_CRCHI,
    PH_DONE
  } phase_t;

  phase_t             phase, phase_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [LEN_W-1:0]   body_length, body_length_next;
  logic [LEN_W-1:0]   bytes_taken, bytes_taken_next;
  logic [POS_W-1:0]   burst_position, burst_position_next;
  logic [START_W-1:0] candidate_start, candidate_start_next;
  logic [7:0]         crc_low_seen, crc_low_seen_next;
  logic               reported, reported_next;

  logic [7:0]         b;
  logic               pos_ok;
  logic               addr_hit, func_hit;
  logic [15:0]        crc_base, crc_upd;
  logic [LEN_W-1:0]   taken_inc, body_sel, frame_len_full;
  logic               hit, fail;

  assign b         = word.rx_byte;
  assign pos_ok    = burst_position < POS_W'(BURST_BYTES);
  assign addr_hit  = (b == cfg.address);
  assign func_hit  = (b == cfg.function_code);
  assign taken_inc = bytes_taken + LEN_W'(1);

  // Continue the running CRC in the body, restart it when a candidate opens
  assign crc_base = ((phase == PH_ADDR && func_hit) || phase == PH_BODY) ? running_crc
                                                                         : CRC_INIT;
  assign crc_upd  = crc_byte(crc_base, b);

  // Byte count arrives as the third frame byte
  assign body_sel = (taken_inc == LEN_W'(3) && body_length == '0)
                    ? ({1'b0, b} + LEN_W'(3)) : body_length;

  assign frame_len_full = body_length + LEN_W'(2);

  // Next state for the word in the input register
  always_comb begin
    phase_next           = phase;
    running_crc_next     = running_crc;
    body_length_next     = body_length;
    bytes_taken_next     = bytes_taken;
    burst_position_next  = burst_position;
    candidate_start_next = candidate_start;
    crc_low_seen_next    = crc_low_seen;
    reported_next        = reported;
    hit                  = 1'b0;
    fail                 = 1'b0;

    if (pos_ok) begin
      burst_position_next = burst_position + POS_W'(1);
      case (phase)
        PH_HUNT: begin
          if (addr_hit) begin
            phase_next           = PH_ADDR;
            candidate_start_next = START_W'(burst_position);
            running_crc_next     = crc_upd;
            bytes_taken_next     = LEN_W'(1);
            body_length_next     = '0;
          end
        end
        PH_ADDR: begin
          if (func_hit) begin
            running_crc_next = crc_upd;
            bytes_taken_next = LEN_W'(2);
            phase_next       = PH_BODY;
            case (cfg.length_rule)
              RULE_FIXED3: body_length_next = LEN_W'(3);
              RULE_FIXED4: body_length_next = LEN_W'(4);
              RULE_FIXED6: body_length_next = LEN_W'(6);
              default:     body_length_next = '0;
            endcase
          end else if (addr_hit) begin
            // Repeated address opens a new candidate here
            candidate_start_next = START_W'(burst_position);
            running_crc_next     = crc_upd;
            bytes_taken_next     = LEN_W'(1);
            body_length_next     = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          running_crc_next = crc_upd;
          bytes_taken_next = taken_inc;
          body_length_next = body_sel;
          if (body_sel != '0 && taken_inc >= body_sel) begin
            phase_next = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          crc_low_seen_next = b;
          phase_next        = PH_CRCHI;
        end
        PH_CRCHI: begin
          if (crc_low_seen == running_crc[7:0] && b == running_crc[15:8]) begin
            hit           = 1'b1;
            reported_next = 1'b1;
            phase_next    = PH_DONE;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        default: ;
      endcase
    end

    // End of burst: report failure if nothing was found, then clear
    if (word.end_of_burst) begin
      fail                 = !hit && !reported;
      phase_next           = PH_HUNT;
      running_crc_next     = CRC_INIT;
      body_length_next     = '0;
      bytes_taken_next     = '0;
      burst_position_next  = '0;
      candidate_start_next = '0;
      crc_low_seen_next    = '0;
      reported_next        = 1'b0;
    end
  end

  assign res_valid        = hit || fail;
  assign res.status       = hit ? STATUS_OK : STATUS_FAIL;
  assign res.frame_start  = hit ? candidate_start : '0;
  assign res.frame_length = hit ? frame_len_full[FLEN_W-1:0] : '0;

  // Advance burst state once per word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      running_crc     <= CRC_INIT;
      body_length     <= '0;
      bytes_taken     <= '0;
      burst_position  <= '0;
      candidate_start <= '0;
      crc_low_seen    <= '0;
      reported        <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      running_crc     <= running_crc_next;
      body_length     <= body_length_next;
      bytes_taken     <= bytes_taken_next;
      burst_position  <= burst_position_next;
      candidate_start <= candidate_start_next;
      crc_low_seen    <= crc_low_seen_next;
      reported        <= reported_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mrrc_out_reg.sv
// Result register: holds one result word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module mrrc_out_reg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire mrrc_pkg::result_t               res,
  output logic                                 free,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 status,
  output logic [mrrc_pkg::START_W-1:0]         frame_start,
  output logic [mrrc_pkg::FLEN_W-1:0]          frame_length
);
  import mrrc_pkg::*;

  result_t held;

  assign free         = !out_valid || out_ready;
  assign status       = held.status;
  assign frame_start  = held.frame_start;
  assign frame_length = held.frame_length;

  // Control: set on load, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: load a new result
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/modbus_rtu_response_checker_unit.sv
// Top level of the Modbus RTU response checker.
// Usage:
//   Input channel (in_valid/in_ready) carries one received byte per word, with
//   end_of_burst marking the last byte of a burst. Output channel
//   (out_valid/out_ready) carries at most one result word per burst: status 0
//   with frame_start and frame_length for the first frame whose CRC-16 checks,
//   or status 1 with zeros when the burst ends with no such frame.
//   Registers on the APB port: 0x0 expected address, 0x4 expected function,
//   0x8 length rule. Write them only while no burst is in flight.
//   Path: an accepted word is held in the input register; when the parser
//   takes it, the result is loaded into the output register, which raises
//   out_valid for the byte that completes the frame or ends the burst.
//   Throughput: one byte per cycle while the result register is free; the byte-wide
//   CRC update and frame state advance are combinational from the input register.
//   Reset clears burst state, empties both registers and restores register
//   defaults (address 1, function 3, length rule 0).
//   A stalled receiver holds the result; one more byte is taken into the input
//   register, then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_checker_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic                         end_of_burst,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              status,
  output logic [mrrc_pkg::START_W-1:0]      frame_start,
  output logic [mrrc_pkg::FLEN_W-1:0]       frame_length,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mrrc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mrrc_pkg::PDATA_W-1:0] pwdata,
  output logic      [mrrc_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import mrrc_pkg::*;

  cfg_t     cfg;
  in_word_t word;
  result_t  res;
  logic     word_valid;
  logic     take;
  logic     res_valid;
  logic     out_free;

  // Take the held word when the result register can accept its outcome
  assign take = word_valid && out_free;

  mrrc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrrc_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .end_of_burst (end_of_burst),
    .take         (take),
    .held_valid   (word_valid),
    .held         (word)
  );

  mrrc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mrrc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (take && res_valid),
    .res          (res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_start  (frame_start),
    .frame_length (frame_length)
  );

endmodule

`default_nettype wire

FILE: sv/mrrc_checker.sv
// Port-level checks for the response checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrrc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         status,
  input wire logic [mrrc_pkg::START_W-1:0] frame_start,
  input wire logic [mrrc_pkg::FLEN_W-1:0]  frame_length
);
  import mrrc_pkg::*;

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("registers not empty after reset");

  // Failure words carry no frame position
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FAIL |-> frame_start == '0 && frame_length == '0)
    else $error("failure word with nonzero frame fields");

  // A found frame holds at least address, function, one body byte and CRC
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> frame_length >= FLEN_W'(5))
    else $error("frame length too short");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_start)
                                && $stable(frame_length))
    else $error("stalled result word changed");

endmodule

bind modbus_rtu_response_checker_unit mrrc_checker u_mrrc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .frame_start  (frame_start),
  .frame_length (frame_length)
);

`default_nettype wire
